FILE: rtl/sparc_unsigned_divide_unit_top_macros.svh
// ----------------------------------------------------------------------------
// SPARC unsigned divide unit assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPARC_UNSIGNED_DIVIDE_UNIT_TOP_MACROS_SVH
`define SPARC_UNSIGNED_DIVIDE_UNIT_TOP_MACROS_SVH

// Checks an implication on every rising edge of i_clk outside reset.
`define SUDU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising edge of i_clk outside reset.
`define SUDU_ASSERT_NEVER(label, cond, msg) \
    `SUDU_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/sudu_pkg.sv
// ----------------------------------------------------------------------------
// SPARC unsigned divide unit package
// Field layout of the instruction word, widths and the pipeline cell types.
// ----------------------------------------------------------------------------
`default_nettype none

package sudu_pkg;

    localparam int DATA_W  = 32;
    localparam int REG_W   = 5;
    localparam int N_CELLS = DATA_W;

    localparam int RD_LSB  = 25;
    localparam int IMM_BIT = 13;
    localparam int SIMM_W  = 13;
    localparam int RS2_W   = 5;

    localparam logic [DATA_W-1:0] QUOT_SAT  = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] QUOT_ZERO = {DATA_W{1'b0}};

    // Side information that rides along with each item through the chain.
    typedef struct packed {
        logic [REG_W-1:0] rd;
        logic             sat;
        logic             zero;
    } t_tag;

    // State held by one divider cell: partial remainder, the shift word that
    // starts as the low dividend half and fills up with quotient bits, and
    // the divisor.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] lq;
        logic [DATA_W-1:0] div;
        t_tag              tag;
    } t_cell_data;

endpackage

`default_nettype wire

FILE: rtl/sudu_if.sv
// ----------------------------------------------------------------------------
// SPARC unsigned divide unit channel interfaces
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sudu_in_if import sudu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] instruction;
    logic [DATA_W-1:0] y_value;
    logic [DATA_W-1:0] rs1_value;
    logic [DATA_W-1:0] rs2_value;

    modport source (output valid, output instruction, output y_value,
                    output rs1_value, output rs2_value, input ready);
    modport sink   (input valid, input instruction, input y_value,
                    input rs1_value, input rs2_value, output ready);
endinterface

interface sudu_out_if import sudu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REG_W-1:0]  dest_reg;
    logic [DATA_W-1:0] quotient;
    logic              write_enable;
    logic              div_zero_trap;

    modport source (output valid, output dest_reg, output quotient,
                    output write_enable, output div_zero_trap, input ready);
    modport sink   (input valid, input dest_reg, input quotient,
                    input write_enable, input div_zero_trap, output ready);
endinterface

`default_nettype wire

FILE: rtl/sudu_cell.sv
// ----------------------------------------------------------------------------
// SPARC unsigned divide unit cell
// One restoring division step with its own pipeline register and handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sudu_cell import sudu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_cell_data i_data,
    output logic            o_ready,
    output logic            o_valid,
    output t_cell_data      o_data,
    input  wire logic       i_ready
);

    logic              r_valid;
    t_cell_data        r_data;
    t_cell_data        n_data;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic              w_qbit;

    // For items that do not saturate the partial remainder stays below the divisor,
    // so the shifted trial value needs one extra bit and the result fits in DATA_W.
    always_comb begin
        w_trial = {i_data.rem, i_data.lq[DATA_W-1]};
        w_diff  = w_trial - {1'b0, i_data.div};
        w_qbit  = ~w_diff[DATA_W];
        n_data     = i_data;
        n_data.rem = w_qbit ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
        n_data.lq  = {i_data.lq[DATA_W-2:0], w_qbit};
    end

    assign o_ready = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sparc_unsigned_divide_unit_top.sv
// ----------------------------------------------------------------------------
// SPARC unsigned divide unit
// Pipelined UDIV: Y:rs1 divided by rs2 or the sign-extended immediate.
// ----------------------------------------------------------------------------
// The unit takes one UDIV item per cycle while the result side does not stall,
// and returns the results in order. The chain holds 32 division cells, each
// producing one quotient bit and holding its item in a register. Every cell
// has its own valid bit, so empty cells fill while a finished result waits at
// the end of the chain. Overflow is detected at entry by comparing Y with the
// divisor, and a zero divisor gives a trap with no write and a zero quotient.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparc_unsigned_divide_unit_top_macros.svh"

module sparc_unsigned_divide_unit_top import sudu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sudu_in_if.sink    i_in,
    sudu_out_if.source o_out
);

    logic              w_valid [0:N_CELLS];
    logic              w_ready [0:N_CELLS];
    t_cell_data        w_data  [0:N_CELLS];

    logic              w_imm;
    logic [DATA_W-1:0] w_simm;
    logic [DATA_W-1:0] w_div;
    t_cell_data        w_last;

    // Decode: the immediate is sign-extended to 32 bits and then unsigned.
    always_comb begin
        w_imm  = i_in.instruction[IMM_BIT];
        w_simm = {{(DATA_W-SIMM_W){i_in.instruction[SIMM_W-1]}},
                  i_in.instruction[SIMM_W-1:0]};
        w_div  = w_imm ? w_simm
                       : {{(DATA_W-RS2_W){1'b0}}, i_in.rs2_value[RS2_W-1:0]} |
                         i_in.rs2_value;
        w_data[0].rem      = i_in.y_value;
        w_data[0].lq       = i_in.rs1_value;
        w_data[0].div      = w_div;
        w_data[0].tag.rd   = i_in.instruction[RD_LSB+REG_W-1:RD_LSB];
        w_data[0].tag.zero = (w_div == QUOT_ZERO);
        // The quotient exceeds 32 bits exactly when Y is not below the divisor.
        w_data[0].tag.sat  = (i_in.y_value >= w_div);
    end

    assign w_valid[0]  = i_in.valid;
    assign i_in.ready  = w_ready[0];

    genvar k;
    generate
        for (k = 0; k < N_CELLS; k++) begin : g_cell
            sudu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .i_data  (w_data[k]),
                .o_ready (w_ready[k]),
                .o_valid (w_valid[k+1]),
                .o_data  (w_data[k+1]),
                .i_ready (w_ready[k+1])
            );
        end
    endgenerate

    assign w_last            = w_data[N_CELLS];
    assign w_ready[N_CELLS]  = o_out.ready;
    assign o_out.valid       = w_valid[N_CELLS];
    assign o_out.dest_reg    = w_last.tag.rd;
    assign o_out.write_enable  = ~w_last.tag.zero;
    assign o_out.div_zero_trap = w_last.tag.zero;
    assign o_out.quotient    = w_last.tag.zero ? QUOT_ZERO :
                               w_last.tag.sat  ? QUOT_SAT  : w_last.lq;

    `SUDU_ASSERT(a_trap_no_write, o_out.valid && o_out.div_zero_trap |-> !o_out.write_enable && (o_out.quotient == QUOT_ZERO), "trap item carries a write or a nonzero quotient")
    `SUDU_ASSERT(a_last_hold, w_valid[N_CELLS] && !o_out.ready |=> w_valid[N_CELLS] && $stable(w_last), "stalled result changed in the last cell")
    `SUDU_ASSERT_NEVER(a_empty_refuses, !w_valid[1] && !i_in.ready, "empty first cell refuses an item")

endmodule

`default_nettype wire
